### design/pmsd_pkg.sv
`timescale 1ns / 1ps
package pmsd_pkg;

  localparam logic [2:0] ST_STARTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_DEPARTED = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_DEPART  = 1'b1;

  localparam logic [0:0] CFG_BOUNDARY = 1'b0;
  localparam logic [0:0] CFG_SERVERS  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_QREAD,
    S_QWAIT,
    S_APPLY,
    S_NSCAN,
    S_OUT
  } fsm_t;

endpackage

### design/pmsd_queue_mem.sv
`timescale 1ns / 1ps
module pmsd_queue_mem #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic                           wr_cls,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  logic [31:0]                    wr_data,
  input  logic                           rd_cls,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output logic [31:0]                    rd_data
);
  logic [31:0] mem [2 << $clog2(QUEUE_DEPTH)];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[{wr_cls, wr_addr}] <= wr_data;
    rd_data_r <= mem[{rd_cls, rd_addr}];
  end

  assign rd_data = rd_data_r;
endmodule

### design/priority_multiserver_dispatcher.sv
`timescale 1ns / 1ps
// Channel | Ports                                        | Transfer
// input   | start, in_op, in_arrival_time, in_job_size   | start && !busy
// result  | out_valid, out_status .. out_jobs_queued     | out_valid, one cycle
// config  | cfg_we, cfg_index, cfg_data                  | cfg_we
// The result follows two scans over the server file, a decide state and the result
// state; a pulled queued job adds S_QREAD, S_QWAIT and S_APPLY, and a departure with
// nothing busy skips the second scan. Busy drops after the result.
// Reset is synchronous, active low; queue memories are not cleared.
// The receiver cannot stall; busy holds off new items until the result is shown.
module priority_multiserver_dispatcher #(
  parameter int MAX_SERVERS = 8,
  parameter int QUEUE_DEPTH = 256,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_arrival_time,
  input  logic [31:0] in_job_size,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [2:0]  out_server_index,
  output logic        out_job_class,
  output logic [31:0] out_event_time,
  output logic        out_started_valid,
  output logic        out_started_class,
  output logic [31:0] out_next_departure_time,
  output logic        out_any_busy,
  output logic [9:0]  out_jobs_in_node,
  output logic [9:0]  out_jobs_queued,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int SB = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CB = $clog2(QUEUE_DEPTH + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam int SRV_W = 1 + TIME_BITS + 1;

  pmsd_pkg::fsm_t state_r, state_nxt;

  logic [31:0] boundary_r;
  logic [3:0]  nserv_r;

  logic                 op_r;
  logic [TIME_BITS-1:0] t_r;
  logic [31:0]          size_r;
  logic                 cls_r;
  logic [SB:0]          cnt_r;
  logic [SB-1:0]        rd_idx_r;
  logic                 found_r;
  logic [SB-1:0]        best_r;
  logic [TIME_BITS-1:0] best_t_r;
  logic                 best_cls_r;
  logic [QB-1:0] head_r [2];
  logic [QB-1:0] tail_r [2];
  logic [CB-1:0] qcnt_r [2];
  logic [9:0]    node_r;
  logic [2:0]    status_r;
  logic          sv_r, scls_r;
  logic [3:0]    nact;
  logic          qsel;

  // server file memory: {busy, time, class}
  logic [SRV_W-1:0] srv_mem [MAX_SERVERS];
  logic [SRV_W-1:0] srv_rd_r;
  logic [SB-1:0]    srv_raddr;
  logic             srv_we;
  logic [SB-1:0]    srv_waddr;
  logic [SRV_W-1:0] srv_wdata;

  always_ff @(posedge clk) begin
    if (srv_we) srv_mem[srv_waddr] <= srv_wdata;
    srv_rd_r <= srv_mem[srv_raddr];
  end

  logic [MAX_SERVERS-1:0] valid_r;
  logic                   rd_busy;
  logic [TIME_BITS-1:0]   rd_time;
  logic                   rd_cls;
  assign rd_busy = srv_rd_r[SRV_W-1] && valid_r[rd_idx_r];
  assign rd_time = valid_r[rd_idx_r] ? srv_rd_r[TIME_BITS:1] : '0;
  assign rd_cls  = valid_r[rd_idx_r] && srv_rd_r[0];

  always_comb begin
    nact = nserv_r;
    if (nserv_r == 4'd0) nact = 4'd1;
    if ({28'd0, nserv_r} > MAX_SERVERS) nact = 4'(MAX_SERVERS);
  end

  assign qsel = (qcnt_r[0] == '0);

  logic [31:0] q_rd;
  logic        q_we;
  pmsd_queue_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_q (
    .clk(clk), .wr_en(q_we), .wr_cls(cls_r), .wr_addr(tail_r[cls_r]),
    .wr_data(size_r), .rd_cls(qsel), .rd_addr(head_r[qsel]), .rd_data(q_rd)
  );

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [31:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [QB-1:0] qinc(input logic [QB-1:0] p);
    return ({1'b0, p} + 1'b1 >= (QB+1)'(QUEUE_DEPTH)) ? '0 : p + 1'b1;
  endfunction

  logic scan_last;
  assign scan_last = (cnt_r == (SB+1)'(MAX_SERVERS));
  logic cand;
  logic has_q;
  assign has_q = (qcnt_r[0] != '0) || (qcnt_r[1] != '0);

  always_comb begin
    state_nxt = state_r;
    srv_raddr = '0;
    srv_we = 1'b0;
    srv_waddr = best_r;
    srv_wdata = '0;
    q_we = 1'b0;
    cand = 1'b0;
    if (op_r == pmsd_pkg::OP_ARRIVAL && state_r == pmsd_pkg::S_SCAN)
      cand = !rd_busy && ({1'b0, rd_idx_r} < (SB+1)'(nact)) &&
             (!found_r || rd_time < best_t_r);
    else
      cand = rd_busy && (!found_r || rd_time < best_t_r);
    unique case (state_r)
      pmsd_pkg::S_IDLE: if (start) state_nxt = pmsd_pkg::S_SCAN;
      pmsd_pkg::S_SCAN, pmsd_pkg::S_NSCAN: begin
        srv_raddr = scan_last ? '0 : cnt_r[SB-1:0];
        if (scan_last)
          state_nxt = (state_r == pmsd_pkg::S_SCAN) ? pmsd_pkg::S_DECIDE : pmsd_pkg::S_OUT;
      end
      pmsd_pkg::S_DECIDE: begin
        if (op_r == pmsd_pkg::OP_ARRIVAL) begin
          state_nxt = pmsd_pkg::S_NSCAN;
          if (found_r) begin
            srv_we = 1'b1;
            srv_wdata = {1'b1, sat_add(t_r, size_r), cls_r};
          end else if ({1'b0, qcnt_r[cls_r]} < (CB+1)'(QUEUE_DEPTH)) begin
            q_we = 1'b1;
          end
        end else if (!found_r) begin
          state_nxt = pmsd_pkg::S_OUT;
        end else if ({1'b0, best_r} < (SB+1)'(nact) && has_q) begin
          state_nxt = pmsd_pkg::S_QREAD;
        end else begin
          srv_we = 1'b1;
          srv_wdata = {1'b0, best_t_r, best_cls_r};
          state_nxt = pmsd_pkg::S_NSCAN;
        end
      end
      pmsd_pkg::S_QREAD: state_nxt = pmsd_pkg::S_QWAIT;
      pmsd_pkg::S_QWAIT: state_nxt = pmsd_pkg::S_APPLY;
      pmsd_pkg::S_APPLY: begin
        srv_we = 1'b1;
        srv_wdata = {1'b1, sat_add(best_t_r, q_rd), qsel};
        state_nxt = pmsd_pkg::S_NSCAN;
      end
      pmsd_pkg::S_OUT: state_nxt = pmsd_pkg::S_IDLE;
      default: state_nxt = pmsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pmsd_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boundary_r <= 32'd1365;
      nserv_r <= 4'd4;
      valid_r <= '0;
      head_r[0] <= '0; head_r[1] <= '0;
      tail_r[0] <= '0; tail_r[1] <= '0;
      qcnt_r[0] <= '0; qcnt_r[1] <= '0;
      node_r <= '0;
      cnt_r <= '0;
      found_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pmsd_pkg::CFG_BOUNDARY) boundary_r <= cfg_data;
        else nserv_r <= cfg_data[3:0];
      end
      if (srv_we) valid_r[srv_waddr] <= 1'b1;
      unique case (state_r)
        pmsd_pkg::S_IDLE: begin
          cnt_r <= '0;
          found_r <= 1'b0;
        end
        pmsd_pkg::S_SCAN, pmsd_pkg::S_NSCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != '0 && cand) found_r <= 1'b1;
        end
        pmsd_pkg::S_DECIDE: begin
          cnt_r <= '0;
          if (op_r == pmsd_pkg::OP_ARRIVAL) begin
            found_r <= 1'b0;
            if (found_r) node_r <= node_r + 1'b1;
            else if (q_we) begin
              tail_r[cls_r] <= qinc(tail_r[cls_r]);
              qcnt_r[cls_r] <= qcnt_r[cls_r] + 1'b1;
              node_r <= node_r + 1'b1;
            end
          end else if (found_r) begin
            found_r <= 1'b0;
            if (node_r != '0) node_r <= node_r - 1'b1;
          end
        end
        pmsd_pkg::S_APPLY: begin
          head_r[qsel] <= qinc(head_r[qsel]);
          qcnt_r[qsel] <= qcnt_r[qsel] - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= srv_raddr;
    if (state_r == pmsd_pkg::S_IDLE && start) begin
      op_r <= in_op;
      t_r <= TIME_BITS'(in_arrival_time);
      size_r <= in_job_size;
      cls_r <= !(in_job_size < boundary_r);
      sv_r <= 1'b0;
      scls_r <= 1'b0;
    end
    if ((state_r == pmsd_pkg::S_SCAN || state_r == pmsd_pkg::S_NSCAN) &&
        cnt_r != '0 && cand) begin
      best_r <= rd_idx_r;
      best_t_r <= rd_time;
      best_cls_r <= rd_cls;
    end
    if (state_r == pmsd_pkg::S_DECIDE) begin
      if (op_r == pmsd_pkg::OP_ARRIVAL) begin
        out_event_time <= 32'(t_r);
        out_job_class <= cls_r;
        out_server_index <= found_r ? 3'(best_r) : 3'd0;
        status_r <= found_r ? pmsd_pkg::ST_STARTED
                  : (q_we ? pmsd_pkg::ST_QUEUED : pmsd_pkg::ST_DROPPED);
      end else if (found_r) begin
        out_event_time <= 32'(best_t_r);
        out_job_class <= best_cls_r;
        out_server_index <= 3'(best_r);
        status_r <= pmsd_pkg::ST_DEPARTED;
      end else begin
        status_r <= pmsd_pkg::ST_NONE;
        out_server_index <= '0;
        out_job_class <= 1'b0;
        out_event_time <= '0;
      end
    end
    if (state_r == pmsd_pkg::S_APPLY) begin
      sv_r <= 1'b1;
      scls_r <= qsel;
    end
  end

  // the scan covers every server; S_OUT rereads server 0 and folds it in combinationally
  logic                 fin_found;
  logic [TIME_BITS-1:0] fin_t;
  assign fin_found = found_r || (state_r == pmsd_pkg::S_OUT && rd_busy);
  assign fin_t = (found_r && !(rd_busy && rd_time < best_t_r)) ? best_t_r
                 : (rd_busy ? rd_time : best_t_r);

  logic [CB:0] qsum;
  assign qsum = {1'b0, qcnt_r[0]} + {1'b0, qcnt_r[1]};

  assign busy = (state_r != pmsd_pkg::S_IDLE);
  assign out_valid = (state_r == pmsd_pkg::S_OUT);
  assign out_status = status_r;
  assign out_started_valid = sv_r;
  assign out_started_class = scls_r;
  assign out_any_busy = fin_found;
  assign out_next_departure_time = fin_found ? 32'(fin_t) : 32'd0;
  assign out_jobs_in_node = node_r;
  assign out_jobs_queued = 10'(qsum);

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("result not followed by idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, qcnt_r[0]} <= (CB+1)'(QUEUE_DEPTH)) else $error("queue overflow");
endmodule
